@@ design/fpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg: shared opcodes for the signed fixed-point ALU
// Holds the operation codes used by the top level and the bench.
// ----------------------------------------------------------------------------
package fpa_pkg;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_GT   = 4'd4,
		OP_LT   = 4'd5,
		OP_GE   = 4'd6,
		OP_LE   = 4'd7,
		OP_EQ   = 4'd8,
		OP_NE   = 4'd9,
		OP_MIN  = 4'd10,
		OP_MAX  = 4'd11,
		OP_INC  = 4'd12,
		OP_DEC  = 4'd13,
		OP_FINT = 4'd14,
		OP_TINT = 4'd15
	} op_t;

endpackage

@@ design/fixed_point_q24_8_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: signed Q24.8 fixed-point ALU
// Result path: operand capture, ALU stage, result select, divider-matched delay line, output register.
// Throughput: one item per cycle while the output is not stalled; the divider pipeline sets the depth.
// A stall on the output freezes the whole pipeline; nothing is dropped.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  cmd,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] result_word,
	output logic        truth,
	output logic        divide_by_zero
);
	localparam int NB     = WORD_BITS + FRAC_BITS;
	localparam int DSTG   = (NB + 3) / 4;
	localparam int PW     = 2 * WORD_BITS;

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: capture operands
	logic                        v_s1;
	fpa_pkg::op_t                op_s1;
	logic signed [WORD_BITS-1:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= fpa_pkg::op_t'(cmd);
			a_s1  <= operand_a[WORD_BITS-1:0];
			b_s1  <= operand_b[WORD_BITS-1:0];
		end
	end

	// stage 2: multiply, simple ops, divider operand prep
	logic                        v_s2;
	fpa_pkg::op_t                op_s2;
	logic signed [PW-1:0]        prod_s2;
	logic [WORD_BITS-1:0]        simp_s2;
	logic                        tr_s2, dz_s2, qneg_s2;
	logic [NB-1:0]               dnum;
	logic [WORD_BITS-1:0]        dden;
	logic [WORD_BITS-1:0]        simp;
	logic                        tr;
	logic                        gt, lt, eq;
	logic [WORD_BITS-1:0]        a_abs, b_abs;

	assign gt    = a_s1 > b_s1;
	assign lt    = a_s1 < b_s1;
	assign eq    = a_s1 == b_s1;
	assign a_abs = a_s1[WORD_BITS-1] ? (~a_s1 + 1'b1) : a_s1;
	assign b_abs = b_s1[WORD_BITS-1] ? (~b_s1 + 1'b1) : b_s1;
	assign dnum  = {a_abs, {FRAC_BITS{1'b0}}};
	assign dden  = (b_s1 == '0) ? {{(WORD_BITS-1){1'b0}}, 1'b1} : b_abs;

	always_comb begin
		simp = '0;
		tr   = 1'b0;
		unique case (op_s1)
			fpa_pkg::OP_ADD:  simp = a_s1 + b_s1;
			fpa_pkg::OP_SUB:  simp = a_s1 - b_s1;
			fpa_pkg::OP_GT:   tr = gt;
			fpa_pkg::OP_LT:   tr = lt;
			fpa_pkg::OP_GE:   tr = !lt;
			fpa_pkg::OP_LE:   tr = !gt;
			fpa_pkg::OP_EQ:   tr = eq;
			fpa_pkg::OP_NE:   tr = !eq;
			fpa_pkg::OP_MIN:  simp = gt ? b_s1 : a_s1;
			fpa_pkg::OP_MAX:  simp = lt ? b_s1 : a_s1;
			fpa_pkg::OP_INC:  simp = a_s1 + 1'b1;
			fpa_pkg::OP_DEC:  simp = a_s1 - 1'b1;
			fpa_pkg::OP_FINT: simp = a_s1 <<< FRAC_BITS;
			fpa_pkg::OP_TINT: simp = a_s1 >>> FRAC_BITS;
			default:          simp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			prod_s2 <= PW'(a_s1) * PW'(b_s1);
			simp_s2 <= simp;
			tr_s2   <= tr;
			dz_s2   <= (op_s1 == fpa_pkg::OP_DIV) && (b_s1 == '0);
			qneg_s2 <= a_s1[WORD_BITS-1] ^ b_s1[WORD_BITS-1];
		end
	end

	// divider runs beside the delay line
	logic [NB-1:0] quo;
	fpa_div #(.NUM_BITS(NB), .DEN_BITS(WORD_BITS), .BPS(4)) u_div (
		.clk (clk),
		.en  (en),
		.num (dnum),
		.den (dden),
		.quo (quo)
	);

	// stage 3: scale product toward zero, pick result
	logic [WORD_BITS-1:0] mres;
	logic signed [PW-1:0] padj;
	assign padj = prod_s2 + (prod_s2[PW-1] ? PW'((1 << FRAC_BITS) - 1) : PW'(0));
	assign mres = WORD_BITS'(padj >>> FRAC_BITS);

	logic [WORD_BITS-1:0] r_s3;
	logic                 tr_s3, dz_s3, isdiv_s3, qneg_s3, v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s3     <= (op_s2 == fpa_pkg::OP_MUL) ? mres : simp_s2;
			tr_s3    <= tr_s2;
			dz_s3    <= dz_s2;
			isdiv_s3 <= op_s2 == fpa_pkg::OP_DIV;
			qneg_s3  <= qneg_s2;
		end
	end

	// delay line matching divider depth (stage 3 already covers two stages)
	localparam int DL = DSTG - 2;
	logic [WORD_BITS+3:0] dl_q [DL+1];
	logic                 dv_q [DL+1];
	assign dl_q[0] = {r_s3, tr_s3, dz_s3, isdiv_s3, qneg_s3};
	assign dv_q[0] = v_s3;
	for (genvar i = 0; i < DL; i++) begin : g_dl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_q[i+1] <= 1'b0;
			end else if (en) begin
				dv_q[i+1] <= dv_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dl_q[i+1] <= dl_q[i];
			end
		end
	end

	// final stage: sign the quotient and register outputs
	logic [WORD_BITS+3:0] tl;
	logic [WORD_BITS-1:0] qw, fin;
	assign tl  = dl_q[DL];
	assign qw  = tl[0] ? (~quo[WORD_BITS-1:0] + 1'b1) : quo[WORD_BITS-1:0];
	assign fin = tl[1] ? (tl[2] ? '0 : qw) : tl[WORD_BITS+3:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_q[DL];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			result_word    <= 32'(signed'(fin));
			truth          <= tl[3];
			divide_by_zero <= tl[2];
		end
	end

endmodule

@@ design/fpa_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div: pipelined restoring divider
// Unsigned quotient of NUM_BITS / DEN_BITS, BPS quotient bits per stage,
// with an enable that freezes every stage while the output is stalled.
// ----------------------------------------------------------------------------
module fpa_div #(
	parameter int NUM_BITS = 40,
	parameter int DEN_BITS = 32,
	parameter int BPS      = 4
) (
	input  logic                clk,
	input  logic                en,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic [NUM_BITS-1:0] quo
);
	localparam int STAGES = (NUM_BITS + BPS - 1) / BPS;

	logic [NUM_BITS-1:0] num_q [STAGES+1];
	logic [DEN_BITS-1:0] den_q [STAGES+1];
	logic [DEN_BITS-1:0] rem_q [STAGES+1];

	assign num_q[0] = num;
	assign den_q[0] = den;
	assign rem_q[0] = '0;

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		logic [NUM_BITS-1:0] n_nxt;
		logic [DEN_BITS-1:0] r_nxt;

		// shift in BPS dividend bits, one trial subtract each
		always_comb begin
			logic [DEN_BITS:0] t;
			n_nxt = num_q[s];
			r_nxt = rem_q[s];
			for (int k = 0; k < BPS; k++) begin
				if ((s * BPS + k) < NUM_BITS) begin
					t = {r_nxt, n_nxt[NUM_BITS-1]};
					n_nxt = {n_nxt[NUM_BITS-2:0], 1'b0};
					if (t >= {1'b0, den_q[s]}) begin
						t = t - {1'b0, den_q[s]};
						n_nxt[0] = 1'b1;
					end
					r_nxt = t[DEN_BITS-1:0];
				end
			end
		end

		// advance stage
		always_ff @(posedge clk) begin
			if (en) begin
				num_q[s+1] <= n_nxt;
				den_q[s+1] <= den_q[s];
				rem_q[s+1] <= r_nxt;
			end
		end
	end

	assign quo = num_q[STAGES];

endmodule

@@ tb/fixed_point_q24_8_alu_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_tb: self-checking bench for the Q24.8 fixed-point ALU
// Drives directed corner items and random items through the valid/stall
// handshake, predicts each result in a scoreboard and checks in order.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_tb;

	localparam int FRAC = 8;
	localparam int WATCH_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic signed [31:0] word;
		logic               truth;
		logic               dz;
	} alu_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [3:0] cmd;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] result_word;
	logic truth;
	logic divide_by_zero;

	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 37;
	int unsigned recv_idle_pct = 72;
	int unsigned idle_cycles = 0;

	// report one mismatch and count it
	task automatic report_mismatch(input string what);
		$display("MISMATCH: %s", what);
		mismatches++;
	endtask

	// scoreboard: predicts results of accepted items, checks returned ones
	class alu_scoreboard;
		alu_result_t pending[$];

		function alu_result_t compute(fpa_pkg::op_t op, logic signed [31:0] a,
				logic signed [31:0] b);
			alu_result_t r;
			logic signed [63:0] wa, wb, w;
			wa = a;
			wb = b;
			w = 0;
			r.truth = 0;
			r.dz = 0;
			case (op)
				fpa_pkg::OP_ADD: w = wa + wb;
				fpa_pkg::OP_SUB: w = wa - wb;
				fpa_pkg::OP_MUL: w = (wa * wb) / 64'sd256;
				fpa_pkg::OP_DIV: begin
					if (b == 0) r.dz = 1;
					else w = (wa * 64'sd256) / wb;
				end
				fpa_pkg::OP_GT: r.truth = a > b;
				fpa_pkg::OP_LT: r.truth = a < b;
				fpa_pkg::OP_GE: r.truth = a >= b;
				fpa_pkg::OP_LE: r.truth = a <= b;
				fpa_pkg::OP_EQ: r.truth = a == b;
				fpa_pkg::OP_NE: r.truth = a != b;
				fpa_pkg::OP_MIN: w = (a > b) ? wb : wa;
				fpa_pkg::OP_MAX: w = (a < b) ? wb : wa;
				fpa_pkg::OP_INC: w = wa + 1;
				fpa_pkg::OP_DEC: w = wa - 1;
				fpa_pkg::OP_FINT: w = wa <<< FRAC;
				default: w = wa >>> FRAC;
			endcase
			r.word = w[31:0];
			return r;
		endfunction

		function void note_item(logic [3:0] c, logic signed [31:0] a,
				logic signed [31:0] b);
			pending.push_back(compute(fpa_pkg::op_t'(c), a, b));
		endfunction

		task check_result(logic signed [31:0] w, logic t, logic d);
			alu_result_t e;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", w));
				return;
			end
			e = pending.pop_front();
			if (w !== e.word)
				report_mismatch($sformatf("word %h expected %h", w, e.word));
			if (t !== e.truth)
				report_mismatch($sformatf("truth %b expected %b", t, e.truth));
			if (d !== e.dz)
				report_mismatch($sformatf("dz %b expected %b", d, e.dz));
		endtask
	endclass

	alu_scoreboard sb = new();

	fixed_point_q24_8_alu u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_word(result_word), .truth(truth),
		.divide_by_zero(divide_by_zero)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// note accepted items, check accepted results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_item(cmd, operand_a, operand_b);
			if (out_valid && !out_stall)
				sb.check_result(result_word, truth, divide_by_zero);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// drive receiver stall at random
	always @(posedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// send one item; hold it until it is accepted
	task automatic send_item(input logic [3:0] c, input logic [31:0] a,
			input logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(5))
			0: return $urandom_range(7) - 4;
			1: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'h0} - $urandom_range(3);
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			3: return $signed($urandom_range(65535)) - 32768;
			default: return $urandom();
		endcase
	endfunction

	task automatic random_phase(input int n);
		logic [31:0] a, b;
		for (int i = 0; i < n; i++) begin
			a = rand_operand();
			b = ($urandom_range(9) == 0) ? a : rand_operand();
			if ($urandom_range(15) == 0) b = 0;
			send_item(4'($urandom_range(15)), a, b);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [31:0] edges [6];
		edges = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h100};
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		cmd = 0;
		operand_a = 0;
		operand_b = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every opcode on extreme operands, plus divide by zero and further corners
		for (int c = 0; c < 16; c++)
			send_item(4'(c), edges[c % 6], edges[(c + 3) % 6]);
		send_item(fpa_pkg::OP_DIV, 32'h7fffffff, 32'h0);
		send_item(fpa_pkg::OP_DIV, 32'h80000000, 32'hffffffff);
		send_item(fpa_pkg::OP_MUL, 32'h80000000, 32'h80000000);
		send_item(fpa_pkg::OP_MUL, 32'hffffff01, 32'h00000001);
		send_item(fpa_pkg::OP_TINT, 32'hffffff01, 32'h0);
		send_item(fpa_pkg::OP_EQ, 32'h80000000, 32'h80000000);
		send_item(fpa_pkg::OP_FINT, 32'h00ffffff, 32'h0);

		random_phase(530);
		// hold off until every outstanding result is back
		in_valid <= 0;
		wait_drained();
		send_idle_pct = 72;
		recv_idle_pct = 37;
		random_phase(530);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(540);

		in_valid <= 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
